/* rtl/dipc_pkg.sv */
// ----------------------------------------------------------------------------
// Dual-issue pairing check package
// Types, opcode and function codes, and stop reason codes shared by the
// decode stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package dipc_pkg;

  localparam int WordW = 32;
  localparam int RegW  = 5;
  localparam int OpW   = 6;

  // Primary opcodes.
  localparam logic [OpW-1:0] OP_SPECIAL = 6'd0;
  localparam logic [OpW-1:0] OP_J       = 6'd2;
  localparam logic [OpW-1:0] OP_JAL     = 6'd3;
  localparam logic [OpW-1:0] OP_BEQ     = 6'd4;
  localparam logic [OpW-1:0] OP_BNE     = 6'd5;
  localparam logic [OpW-1:0] OP_BLEZ    = 6'd6;
  localparam logic [OpW-1:0] OP_BGTZ    = 6'd7;
  localparam logic [OpW-1:0] OP_LUI     = 6'd15;
  localparam logic [OpW-1:0] OP_MUL     = 6'd28;
  localparam logic [OpW-1:0] OP_LW      = 6'd35;
  localparam logic [OpW-1:0] OP_SW      = 6'd43;

  // Function codes under the special opcode.
  localparam logic [OpW-1:0] FN_SLL  = 6'd0;
  localparam logic [OpW-1:0] FN_SRL  = 6'd2;
  localparam logic [OpW-1:0] FN_SRA  = 6'd3;
  localparam logic [OpW-1:0] FN_JR   = 6'd8;
  localparam logic [OpW-1:0] FN_JALR = 6'd9;

  localparam logic [RegW-1:0] LINK_REG = 5'd31;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_CTRL   = 2'd1,
    STOP_STRUCT = 2'd2,
    STOP_DATA   = 2'd3
  } stop_reason_t;

  typedef struct packed {
    logic [WordW-1:0] first_word;
    logic [WordW-1:0] second_word;
  } dipc_in_t;

  typedef struct packed {
    logic         pair_ok;
    stop_reason_t stop_reason;
    logic         also_data_dep;
  } dipc_out_t;

  // Per-word decode summary used by the pairing rules.
  typedef struct packed {
    logic            is_ctrl;
    logic            is_mem;
    logic            is_mul;
    logic            wr_en;
    logic [RegW-1:0] wr_reg;
    logic            rd_rs;
    logic            rd_rt;
    logic [RegW-1:0] rs;
    logic [RegW-1:0] rt;
  } dipc_dec_t;

endpackage

`default_nettype wire

/* rtl/dual_issue_pairing_check.sv */
// ----------------------------------------------------------------------------
// Dual-issue pairing check
// Decides whether two consecutive instruction words may issue in one cycle.
// ----------------------------------------------------------------------------
// Each start transfer gives one result, strobed on out_valid from the result register.
// Throughput: one pair per cycle; busy is always low, so start may be held high.
// The path is an input register, decode of both words and the pairing rules,
// then the result register.
// Reset (rst_n, synchronous) clears the valid bits of both stages only.
`default_nettype none

module dual_issue_pairing_check
  import dipc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dipc_in_t in_item,
  output logic          out_valid,
  output dipc_out_t     out_item
);

  logic      in_valid_r;
  logic      in_valid_nxt;
  dipc_in_t  in_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  dipc_out_t out_item_r;
  dipc_out_t out_item_nxt;
  dipc_dec_t dec_a;
  dipc_dec_t dec_b;
  logic      dep;
  logic      struct_hit;

  assign busy         = 1'b0;
  assign in_valid_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_item_r <= in_item;
    end
  end

  dipc_decode u_dec_a (
    .word (in_item_r.first_word),
    .dec  (dec_a)
  );

  dipc_decode u_dec_b (
    .word (in_item_r.second_word),
    .dec  (dec_b)
  );

  // RAW through either source of the second word, or WAW on the same register.
  assign dep = dec_a.wr_en &&
               ((dec_b.rd_rs && (dec_b.rs == dec_a.wr_reg)) ||
                (dec_b.rd_rt && (dec_b.rt == dec_a.wr_reg)) ||
                (dec_b.wr_en && (dec_b.wr_reg == dec_a.wr_reg)));

  assign struct_hit = (dec_a.is_mem && dec_b.is_mem) || (dec_a.is_mul && dec_b.is_mul);

  always_comb begin
    out_item_nxt = '0;
    if (dec_a.is_ctrl) begin
      out_item_nxt.stop_reason = STOP_CTRL;
    end else if (struct_hit) begin
      out_item_nxt.stop_reason   = STOP_STRUCT;
      out_item_nxt.also_data_dep = dep;
    end else if (dep) begin
      out_item_nxt.stop_reason = STOP_DATA;
    end else begin
      out_item_nxt.pair_ok     = 1'b1;
      out_item_nxt.stop_reason = STOP_NONE;
    end
  end

  assign out_valid_nxt = in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every transfer taken produces a result strobe through the input and result registers.
  a_two_cycle_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing two cycles after start transfer");

  a_pair_ok_matches_reason : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.pair_ok == (out_item.stop_reason == STOP_NONE)))
    else $error("pair_ok disagrees with stop_reason");

  a_dep_only_on_struct : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.also_data_dep) |-> (out_item.stop_reason == STOP_STRUCT))
    else $error("also_data_dep set outside a structural stop");

  a_ctrl_first : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && dec_a.is_ctrl) |=> (out_item.stop_reason == STOP_CTRL))
    else $error("control instruction in slot one did not give a control stop");

  a_data_stop_has_dep : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !dec_a.is_ctrl && !struct_hit && dep) |=>
      (out_item.stop_reason == STOP_DATA))
    else $error("dependency without structural or control hazard not reported");

endmodule

`default_nettype wire

/* rtl/dipc_decode.sv */
// ----------------------------------------------------------------------------
// Dual-issue pairing check: instruction decode
// Classifies one instruction word and extracts its source and destination
// register usage.
// ----------------------------------------------------------------------------
`default_nettype none

module dipc_decode
  import dipc_pkg::*;
(
  input  wire logic [WordW-1:0] word,
  output dipc_dec_t             dec
);

  logic [OpW-1:0]  op;
  logic [OpW-1:0]  fn;
  logic [RegW-1:0] rd;
  logic            is_hlt;

  assign op     = word[31:26];
  assign fn     = word[5:0];
  assign rd     = word[15:11];
  assign is_hlt = (word == '0);

  always_comb begin
    dec        = '0;
    dec.rs     = word[25:21];
    dec.rt     = word[20:16];
    dec.is_mem = (op == OP_LW) || (op == OP_SW);
    dec.is_mul = (op == OP_MUL);

    case (op)
      OP_SPECIAL: begin
        dec.is_ctrl = is_hlt || (fn == FN_JR) || (fn == FN_JALR);
        dec.wr_en   = !is_hlt && (fn != FN_JR);
        dec.wr_reg  = rd;
        if (fn inside {FN_SLL, FN_SRL, FN_SRA}) begin
          dec.rd_rt = !is_hlt;
        end else if (fn inside {FN_JR, FN_JALR}) begin
          dec.rd_rs = 1'b1;
        end else begin
          dec.rd_rs = 1'b1;
          dec.rd_rt = 1'b1;
        end
      end
      OP_J: begin
        dec.is_ctrl = 1'b1;
      end
      OP_JAL: begin
        dec.is_ctrl = 1'b1;
        dec.wr_en   = 1'b1;
        dec.wr_reg  = LINK_REG;
      end
      OP_BEQ, OP_BNE: begin
        dec.is_ctrl = 1'b1;
        dec.rd_rs   = 1'b1;
        dec.rd_rt   = 1'b1;
      end
      OP_BLEZ, OP_BGTZ: begin
        dec.is_ctrl = 1'b1;
        dec.rd_rs   = 1'b1;
      end
      OP_MUL: begin
        dec.wr_en  = 1'b1;
        dec.wr_reg = rd;
        dec.rd_rs  = 1'b1;
        dec.rd_rt  = 1'b1;
      end
      OP_SW: begin
        dec.rd_rs = 1'b1;
        dec.rd_rt = 1'b1;
      end
      OP_LUI: begin
        dec.wr_en  = 1'b1;
        dec.wr_reg = dec.rt;
      end
      default: begin
        // Loads, immediate ALU ops and unlisted opcodes read rs, write rt.
        dec.wr_en  = 1'b1;
        dec.wr_reg = dec.rt;
        dec.rd_rs  = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire
